@@ rtl/assert_macros.svh @@
// Assertion macros used by the buffer pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define BPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// A condition that must never be true outside reset.
`define BPF_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define BPF_ASSERT(lbl, clk, rst_n, prop)
`define BPF_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/bpf_pkg.sv @@
// Types and constants of the buffer pool.
package bpf_pkg;

	localparam int ID_W   = 10;
	localparam int DIM_W  = 16;
	localparam int FMT_W  = 8;
	localparam int MAXE_W = 4;
	localparam int OP_W   = 2;

	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 56;
	localparam int OUT_TUSER_W = 2;

	localparam logic [MAXE_W-1:0] MAXE_RESET = 4'd4;

	typedef enum logic [OP_W-1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REL_CHK,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [FMT_W-1:0] format;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] width;
		logic [ID_W-1:0]  id;
	} entry_t;

endpackage

@@ rtl/bpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bpf_ram #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/buffer_pool_fit_and_age_evict.sv @@
// Top level of the free buffer pool: exact-size else first-fit acquire, oldest-first eviction.
// One word is handled at a time; one pool entry is read per cycle from a single RAM port.
// Acquire: a scan of the pool, then on a hit a shift that closes the gap, then the output.
// Release: the append and a limit check, plus a shift when the oldest entry is evicted;
// clear, none and zero-size release go straight out. A word is taken only in the idle state.
// Reset empties the pool at once (count to zero) and sets max_entries to 4; no clearing pass.
`include "assert_macros.svh"
module buffer_pool_fit_and_age_evict import bpf_pkg::*; #(
	parameter int POOL_DEPTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [MAXE_W-1:0]      cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// width[15:0], height[31:16], format[39:32], buf_id[49:40], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// op[1:0]
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_id[9:0], out_width[25:10], out_height[41:26], dropped_id[51:42], zero fill above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// hit[0], dropped[1]
	output logic [OUT_TUSER_W-1:0] m_tuser
);

	localparam int SLOTS = POOL_DEPTH + 1;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int LW    = (CW > MAXE_W) ? CW : MAXE_W;

	state_t state_q, state_d;

	logic [CW-1:0]     cnt_q;
	logic [MAXE_W-1:0] max_q;
	logic [CW-1:0]     lim;
	logic [LW-1:0]     max_ext;

	logic [DIM_W-1:0] w_q, h_q;
	logic [FMT_W-1:0] f_q;

	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          found_q;
	logic [AW-1:0] pick_q;

	logic             hit_q, drop_q;
	logic [ID_W-1:0]  rid_q, did_q;
	logic [DIM_W-1:0] rw_q, rh_q;

	logic             out_vld_q, out_hit_q, out_drop_q;
	logic [ID_W-1:0]  out_id_q, out_did_q;
	logic [DIM_W-1:0] out_w_q, out_h_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;

	logic             acc, rel_ok, issue, fit, exact, scan_end, shift_end, evict, out_load;
	op_t              op_in;
	entry_t           in_e;
	logic [AW-1:0]    rm_pos;

	assign op_in       = op_t'(s_tuser[OP_W-1:0]);
	assign in_e.id     = s_tdata[49:40];
	assign in_e.width  = s_tdata[15:0];
	assign in_e.height = s_tdata[31:16];
	assign in_e.format = s_tdata[39:32];

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign rel_ok   = (in_e.width != '0) && (in_e.height != '0);

	// A stored limit of zero behaves as one; anything past the pool depth is clipped.
	assign max_ext = LW'(max_q);
	always_comb begin
		if (max_q == '0) begin
			lim = CW'(1);
		end else if (max_ext > LW'(POOL_DEPTH)) begin
			lim = CW'(POOL_DEPTH);
		end else begin
			lim = CW'(max_ext);
		end
	end

	// Shared compare unit: one pooled entry against the request per cycle.
	assign fit   = rd_vld_s1 && (ram_rdata.format == f_q) &&
	               (ram_rdata.width >= w_q) && (ram_rdata.height >= h_q);
	assign exact = fit && (ram_rdata.width == w_q) && (ram_rdata.height == h_q);

	assign issue     = (idx_q < cnt_q) && !((state_q == ST_SCAN) && exact);
	assign scan_end  = (idx_q >= cnt_q) && !rd_vld_s1;
	assign shift_end = (idx_q >= cnt_q) && !rd_vld_s1;
	assign evict     = (cnt_q > lim);
	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_tready);
	assign rm_pos    = exact ? rd_idx_s1 : pick_q;

	bpf_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[AW-1:0];
		ram_wdata = in_e;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					unique case (op_in)
						OP_ACQUIRE: state_d = ST_SCAN;
						OP_RELEASE: begin
							if (rel_ok) begin
								ram_we  = (cnt_q < CW'(SLOTS));
								state_d = ST_REL_CHK;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_CLEAR: state_d = ST_DONE;
						OP_NONE:  state_d = ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				ram_raddr = idx_q[AW-1:0];
				if (exact || (scan_end && found_q)) begin
					state_d = ST_SHIFT;
				end else if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_REL_CHK: begin
				state_d = evict ? ST_SHIFT : ST_DONE;
			end
			ST_SHIFT: begin
				// Move each later entry down by one to close the gap.
				ram_raddr = idx_q[AW-1:0];
				ram_we    = rd_vld_s1;
				ram_waddr = rd_idx_s1 - AW'(1);
				ram_wdata = ram_rdata;
				if (shift_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			max_q     <= MAXE_RESET;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
				cnt_q <= '0;
			end else if (acc && op_in == OP_CLEAR) begin
				cnt_q <= '0;
			end else if (acc && op_in == OP_RELEASE && rel_ok && cnt_q < CW'(SLOTS)) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == ST_SHIFT && shift_end) begin
				cnt_q <= cnt_q - CW'(1);
			end

			if (state_q == ST_SCAN || state_q == ST_SHIFT) begin
				rd_vld_s1 <= issue && !(state_q == ST_SCAN && scan_end && found_q);
			end else begin
				rd_vld_s1 <= 1'b0;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				w_q     <= in_e.width;
				h_q     <= in_e.height;
				f_q     <= in_e.format;
				idx_q   <= '0;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				rid_q   <= '0;
				rw_q    <= '0;
				rh_q    <= '0;
				drop_q  <= 1'b0;
				did_q   <= '0;
			end
			ST_SCAN: begin
				if (fit && (exact || !found_q)) begin
					found_q <= 1'b1;
					pick_q  <= rd_idx_s1;
					hit_q   <= 1'b1;
					rid_q   <= ram_rdata.id;
					rw_q    <= ram_rdata.width;
					rh_q    <= ram_rdata.height;
				end
				if (exact || (scan_end && found_q)) begin
					idx_q <= CW'(rm_pos) + CW'(1);
				end else if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_REL_CHK: begin
				// The read of the oldest entry was issued when the word was taken.
				if (evict) begin
					drop_q <= 1'b1;
					did_q  <= ram_rdata.id;
				end
				idx_q <= CW'(1);
			end
			ST_SHIFT: begin
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_hit_q  <= hit_q;
			out_id_q   <= rid_q;
			out_w_q    <= rw_q;
			out_h_q    <= rh_q;
			out_drop_q <= drop_q;
			out_did_q  <= did_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, out_did_q, out_h_q, out_w_q, out_id_q};
	assign m_tuser  = {out_drop_q, out_hit_q};

	`BPF_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CW'(SLOTS))
	`BPF_ASSERT(a_idle_within_limit, clk, arst_n, (state_q == ST_IDLE) |-> (cnt_q <= lim))
	`BPF_ASSERT(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	`BPF_NEVER(a_hit_and_drop, clk, arst_n, m_tvalid && m_tuser[0] && m_tuser[1])

endmodule

@@ tb/sv/buffer_pool_fit_and_age_evict_tb.sv @@
// Self-checking testbench for the buffer pool: acquire fit order, release, eviction and clear.
module buffer_pool_fit_and_age_evict_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpf_pkg::*;

	localparam int DEPTH       = 8;
	localparam int WORD_COUNT  = 800;
	localparam int PHASES      = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int SHOW_LIMIT  = 40;

	// One expected output word.
	typedef struct packed {
		logic             hit;
		logic [ID_W-1:0]  id;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             dropped;
		logic [ID_W-1:0]  dropped_id;
	} outcome_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [MAXE_W-1:0]      cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	// width[15:0], height[31:16], format[39:32], buf_id[49:40], zero fill above
	logic [IN_TDATA_W-1:0]  s_tdata;
	// op[1:0]
	logic [IN_TUSER_W-1:0]  s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// out_id[9:0], out_width[25:10], out_height[41:26], dropped_id[51:42], zero fill above
	logic [OUT_TDATA_W-1:0] m_tdata;
	// hit[0], dropped[1]
	logic [OUT_TUSER_W-1:0] m_tuser;

	entry_t            free_list[$];
	outcome_t          outcomes[$];
	outcome_t          want;
	logic [MAXE_W-1:0] max_entries;
	int                err_count;
	int                result_count;
	int                word_count;
	int                hit_count;
	int                drop_count;
	int                limit_writes;
	int                useful;
	int                idle_cycles;
	int                sink_wait;
	bit                calm;

	buffer_pool_fit_and_age_evict #(.POOL_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int keep_limit();
		if (max_entries == 0)
			return 1;
		if (max_entries > DEPTH)
			return DEPTH;
		return int'(max_entries);
	endfunction

	// Updates the pool copy for one accepted word and queues the word it must produce.
	task automatic predict_pool(op_t op, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [FMT_W-1:0] f, logic [ID_W-1:0] id);
		outcome_t res;
		entry_t   e;
		int       pick;
		res = '0;
		pick = -1;
		case (op)
			OP_ACQUIRE: begin
				// Oldest first; an exact size ends the scan, otherwise the first fit stays.
				foreach (free_list[i]) begin
					if (free_list[i].format == f && free_list[i].width >= w &&
							free_list[i].height >= h) begin
						if (free_list[i].width == w && free_list[i].height == h) begin
							pick = i;
							break;
						end
						if (pick < 0)
							pick = i;
					end
				end
				if (pick >= 0) begin
					res.hit = 1'b1;
					res.id = free_list[pick].id;
					res.width = free_list[pick].width;
					res.height = free_list[pick].height;
					free_list.delete(pick);
					hit_count++;
				end
			end
			OP_RELEASE: begin
				if (w != 0 && h != 0) begin
					e.id = id;
					e.width = w;
					e.height = h;
					e.format = f;
					free_list.insert(free_list.size(), e);
					if (free_list.size() > keep_limit()) begin
						res.dropped = 1'b1;
						res.dropped_id = free_list[0].id;
						void'(free_list.pop_front());
						drop_count++;
					end
				end
			end
			OP_CLEAR: begin
				free_list.delete();
			end
			default: begin
			end
		endcase
		outcomes.insert(outcomes.size(), res);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] exp_val);
		err_count++;
		if (err_count <= SHOW_LIMIT)
			$display("MISMATCH %s at result %0d: got %0d, expected %0d",
				what, result_count, got, exp_val);
	endtask

	task automatic compare_field(string what, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report(what, got, exp_val);
	endtask

	// Sends one word after a random gap (none when calm) and returns once it is accepted.
	task automatic send_word(op_t op, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			logic [FMT_W-1:0] f, logic [ID_W-1:0] id);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, id, f, h, w};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_pool(op, w, h, f, id);
		word_count++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Every word yields a result, so an empty expectation queue means the block is idle.
	task automatic write_limit(logic [MAXE_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_entries = v;
		free_list.delete();
		limit_writes++;
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 20)
			return DIM_W'($urandom);
		return DIM_W'($urandom_range(1, 4) * 32);
	endfunction

	// Mixed words; most acquires aim at pooled buffers so that hits and fit order get exercised.
	task automatic send_random();
		int               r;
		int               k;
		op_t              op;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [FMT_W-1:0] f;
		logic [ID_W-1:0]  id;
		r = $urandom_range(0, 99);
		id = ID_W'($urandom_range(0, 1023));
		f = ($urandom_range(0, 9) == 0) ? FMT_W'($urandom_range(0, 255))
			: FMT_W'($urandom_range(0, 3));
		w = pick_dim();
		h = pick_dim();
		if (r < 45) begin
			op = OP_RELEASE;
		end else if (r < 88) begin
			op = OP_ACQUIRE;
			if (free_list.size() != 0 && $urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, free_list.size() - 1);
				f = free_list[k].format;
				w = $urandom_range(0, 1) ? free_list[k].width
					: DIM_W'($urandom_range(0, free_list[k].width));
				h = $urandom_range(0, 1) ? free_list[k].height
					: DIM_W'($urandom_range(0, free_list[k].height));
			end
		end else if (r < 95) begin
			op = OP_CLEAR;
		end else begin
			op = OP_NONE;
		end
		if (!(op == OP_NONE || (op == OP_RELEASE && (w == 0 || h == 0))))
			useful++;
		send_word(op, w, h, f, id);
	endtask

	task automatic test_empty_and_ignored();
		send_word(OP_ACQUIRE, 16, 16, 0, 5);
		send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF);
		send_word(OP_RELEASE, 0, 10, 1, 7);
		send_word(OP_RELEASE, 10, 0, 1, 8);
		send_word(OP_CLEAR, 1, 1, 1, 9);
	endtask

	task automatic test_fit_order();
		send_word(OP_RELEASE, 64, 64, 1, 1);
		send_word(OP_RELEASE, 32, 32, 1, 2);
		send_word(OP_RELEASE, 32, 32, 1, 3);
		send_word(OP_RELEASE, 128, 64, 2, 4);
		// Exact size wins over an older larger buffer; of two equal ones the older goes.
		send_word(OP_ACQUIRE, 32, 32, 1, 0);
		// No exact size: the oldest fitting buffer is taken, not the smallest.
		send_word(OP_ACQUIRE, 30, 30, 1, 0);
		send_word(OP_ACQUIRE, 16, 16, 3, 0);
		send_word(OP_ACQUIRE, 200, 10, 2, 0);
		send_word(OP_RELEASE, 16'hFFFF, 16'hFFFF, 8'hFF, 5);
		send_word(OP_RELEASE, 8, 8, 0, 6);
		send_word(OP_RELEASE, 8, 8, 0, 7);
		send_word(OP_ACQUIRE, 0, 0, 8'hFF, 0);
		send_word(OP_RELEASE, 16'hFFFF, 16'hFFFF, 8'hFF, 10'h3FF);
		send_word(OP_ACQUIRE, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
		send_word(OP_CLEAR, 0, 0, 0, 0);
		send_word(OP_ACQUIRE, 8, 8, 0, 0);
	endtask

	task automatic test_limit_floor();
		// A limit of zero keeps one buffer.
		write_limit(4'd0);
		send_word(OP_RELEASE, 20, 20, 4, 11);
		send_word(OP_RELEASE, 20, 20, 4, 12);
		send_word(OP_ACQUIRE, 20, 20, 4, 0);
	endtask

	task automatic test_random_phases();
		logic [MAXE_W-1:0] limits [PHASES];
		limits = '{4'd15, 4'd1, 4'd8, 4'd3, 4'd9, 4'd0, 4'd2, 4'd6};
		limits[5] = MAXE_W'($urandom_range(0, 15));
		for (int p = 0; p < PHASES; p++) begin
			write_limit(limits[p]);
			calm = (p == 2);
			useful = 0;
			while (useful < WORD_COUNT / PHASES)
				send_random();
		end
		calm = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (outcomes.size() == 0) begin
				report("result with nothing expected", 32'(m_tuser), 0);
			end else begin
				want = outcomes.pop_front();
				compare_field("hit", 32'(m_tuser[0]), 32'(want.hit));
				compare_field("dropped", 32'(m_tuser[1]), 32'(want.dropped));
				compare_field("out_id", 32'(m_tdata[9:0]), 32'(want.id));
				compare_field("out_width", 32'(m_tdata[25:10]), 32'(want.width));
				compare_field("out_height", 32'(m_tdata[41:26]), 32'(want.height));
				compare_field("dropped_id", 32'(m_tdata[51:42]), 32'(want.dropped_id));
				compare_field("tdata fill", 32'(m_tdata[55:52]), 0);
			end
			result_count++;
			sink_wait = calm ? 0 : $urandom_range(0, 3);
			m_tready <= (sink_wait == 0);
		end else if (sink_wait > 0) begin
			sink_wait--;
			if (sink_wait == 0)
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b1;
		max_entries = MAXE_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_ignored();
		test_fit_order();
		test_limit_floor();
		test_random_phases();

		drain();
		repeat (40) @(posedge clk);
		if (outcomes.size() != 0)
			report("results never produced", outcomes.size(), 0);
		$display("Ran %0d words under %0d limit settings: %0d acquire hits, %0d evictions.",
			word_count, limit_writes, hit_count, drop_count);
		$display("Mismatches found: %0d.", err_count);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bpf_pkg.sv
rtl/bpf_ram.sv
rtl/buffer_pool_fit_and_age_evict.sv
tb/sv/buffer_pool_fit_and_age_evict_tb.sv
